>>> rtl/bst_pkg.sv
package bst_pkg;

  localparam int unsigned STORE_DEPTH = 32;
  localparam int unsigned POS_W       = 5;
  localparam int unsigned MEAN_W      = 16;
  localparam int unsigned MAX_FAR_Q   = 15;

  typedef struct packed {
    logic [5:0]  bin_index;
    logic [15:0] far_value;
    logic [15:0] near_value;
    logic [4:0]  far_q_format;
    logic        last_bin;
  } bst_in_t;

  typedef struct packed {
    logic [31:0] far_binary;
    logic [31:0] near_binary;
    logic        frame_error;
  } bst_out_t;

  // mean + floor((value - mean) / 2^shift), result stays within 16 bits
  function automatic logic [MEAN_W-1:0] smooth(input logic [MEAN_W-1:0] mean,
                                               input logic [MEAN_W-1:0] value,
                                               input int unsigned shift);
    logic signed [MEAN_W:0] diff;
    logic signed [MEAN_W:0] step;
    logic signed [MEAN_W:0] sum;
    diff = $signed({1'b0, value}) - $signed({1'b0, mean});
    step = diff >>> shift;
    sum  = $signed({1'b0, mean}) + step;
    return sum[MEAN_W-1:0];
  endfunction

endpackage

>>> rtl/bst_stream_if.sv
interface bst_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/binary_spectrum_thresholder_core.sv
// Adaptive binary thresholding of far-end and near-end magnitude spectra.
// in_bus carries one spectrum bin per beat (bin index, far and near
// magnitudes, far Q format, last-bin mark); out_bus carries one beat per
// frame with the far and near binary words and the frame error flag.
// Bins BAND_FIRST..BAND_LAST each own a far and a near running mean held in
// two 32-entry synchronous RAMs; every in-band bin does a read-modify-write
// of its entry, and a bin whose far Q exceeds 15 is dropped and flags error.
// Throughput: one bin per cycle unless a stalled result beat holds the update
// stage, set by the single RAM read and write port pair; a back-to-back hit
// on the same entry is forwarded. The last bin's RAM read and update stage
// load as it is taken, the output register as the update stage advances.
// Reset (rst_n low, synchronous) clears the per-entry valid bits, so all
// means read as zero at once; no clearing pass is needed. Binary words and
// the error flag clear as well.
// When the receiver stalls, the result beat holds in the output register;
// bins keep flowing until a second last bin reaches the update stage, which
// then holds and deasserts in_bus.ready until the pending beat is taken.
module binary_spectrum_thresholder_core #(
  parameter int BAND_FIRST    = 12,
  parameter int BAND_LAST     = 43,
  parameter int SPECTRUM_BINS = 64,
  parameter int SMOOTH_SHIFT  = 6
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  bst_stream_if.sink                            in_bus,
  bst_stream_if.source                          out_bus
);
  import bst_pkg::*;

  localparam logic [8:0] FIRST_W = 9'(BAND_FIRST);
  localparam logic [8:0] LAST_W  = 9'(BAND_LAST);
  localparam logic [8:0] BINS_W  = 9'(SPECTRUM_BINS);
  localparam logic [8:0] DEPTH_W = 9'(STORE_DEPTH);

  logic [MEAN_W-1:0] far_mem  [STORE_DEPTH];
  logic [MEAN_W-1:0] near_mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] valid_r;

  bst_in_t   in_data;
  logic      in_fire;
  logic [8:0] bin_ext;
  logic [8:0] bin_off;
  logic      in_band;
  logic      in_err;
  logic [POS_W-1:0] in_pos;

  // update stage
  logic             s1_valid_r;
  logic             s1_upd_r;
  logic             s1_err_r;
  logic             s1_last_r;
  logic [POS_W-1:0] s1_pos_r;
  logic [MEAN_W-1:0] s1_far_val_r;
  logic [MEAN_W-1:0] s1_near_val_r;
  logic [MEAN_W-1:0] far_rd_r;
  logic [MEAN_W-1:0] near_rd_r;
  logic             rd_vld_r;
  logic             fwd_hit_r;
  logic [MEAN_W-1:0] fwd_far_r;
  logic [MEAN_W-1:0] fwd_near_r;

  logic             s1_go;
  logic             s1_wr;
  logic [MEAN_W-1:0] far_old;
  logic [MEAN_W-1:0] near_old;
  logic [MEAN_W-1:0] far_new;
  logic [MEAN_W-1:0] near_new;
  logic [31:0]      far_acc_r;
  logic [31:0]      near_acc_r;
  logic             err_r;
  logic [31:0]      far_acc_nxt;
  logic [31:0]      near_acc_nxt;
  logic             err_nxt;

  logic             out_valid_r;
  bst_out_t         out_data_r;

  assign in_data = in_bus.data;
  assign bin_ext = {3'b000, in_data.bin_index};
  assign bin_off = bin_ext - FIRST_W;
  assign in_band = (bin_ext >= FIRST_W) && (bin_ext <= LAST_W) &&
                   (bin_ext < BINS_W) && (bin_off < DEPTH_W);
  assign in_err  = in_data.far_q_format > 5'(MAX_FAR_Q);
  assign in_pos  = bin_off[POS_W-1:0];

  assign s1_go     = s1_valid_r && (!s1_last_r || !out_valid_r || out_bus.ready);
  assign in_bus.ready = !s1_valid_r || s1_go;
  assign in_fire   = in_bus.valid && in_bus.ready;
  assign s1_wr     = s1_go && s1_upd_r;

  // pick the freshest mean: the previous bin's forwarded write, else RAM, else reset value
  always_comb begin
    if (fwd_hit_r) begin
      far_old  = fwd_far_r;
      near_old = fwd_near_r;
    end else if (rd_vld_r) begin
      far_old  = far_rd_r;
      near_old = near_rd_r;
    end else begin
      far_old  = '0;
      near_old = '0;
    end
    far_new  = smooth(far_old, s1_far_val_r, SMOOTH_SHIFT);
    near_new = smooth(near_old, s1_near_val_r, SMOOTH_SHIFT);

    far_acc_nxt  = far_acc_r;
    near_acc_nxt = near_acc_r;
    if (s1_upd_r) begin
      if (s1_far_val_r > far_new) begin
        far_acc_nxt[s1_pos_r] = 1'b1;
      end
      if (s1_near_val_r > near_new) begin
        near_acc_nxt[s1_pos_r] = 1'b1;
      end
    end
    err_nxt = err_r | s1_err_r;
  end

  // RAM read and write
  always_ff @(posedge clk) begin
    if (in_fire) begin
      far_rd_r  <= far_mem[in_pos];
      near_rd_r <= near_mem[in_pos];
    end
    if (s1_wr) begin
      far_mem[s1_pos_r]  <= far_new;
      near_mem[s1_pos_r] <= near_new;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_upd_r      <= in_band && !in_err;
      s1_err_r      <= in_err;
      s1_last_r     <= in_data.last_bin;
      s1_pos_r      <= in_pos;
      s1_far_val_r  <= in_data.far_value;
      s1_near_val_r <= in_data.near_value;
      rd_vld_r      <= valid_r[in_pos];
      // same entry written this cycle: RAM returns the stale value
      fwd_hit_r     <= s1_wr && (s1_pos_r == in_pos);
      fwd_far_r     <= far_new;
      fwd_near_r    <= near_new;
    end
    if (s1_go && s1_last_r) begin
      out_data_r.far_binary  <= far_acc_nxt;
      out_data_r.near_binary <= near_acc_nxt;
      out_data_r.frame_error <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      valid_r     <= '0;
      far_acc_r   <= '0;
      near_acc_r  <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_wr) begin
        valid_r[s1_pos_r] <= 1'b1;
      end
      if (s1_go) begin
        if (s1_last_r) begin
          far_acc_r  <= '0;
          near_acc_r <= '0;
          err_r      <= 1'b0;
        end else begin
          far_acc_r  <= far_acc_nxt;
          near_acc_r <= near_acc_nxt;
          err_r      <= err_nxt;
        end
      end
      out_valid_r <= (out_valid_r && !out_bus.ready) || (s1_go && s1_last_r);
    end
  end

  assign out_bus.valid = out_valid_r;
  assign out_bus.data  = out_data_r;

endmodule

>>> sim/testbench.sv
module testbench;
  import bst_pkg::*;

  localparam int BAND_FIRST    = 12;
  localparam int BAND_LAST     = 43;
  localparam int SPECTRUM_BINS = 64;
  localparam int SMOOTH_SHIFT  = 6;
  localparam int ITEM_TARGET   = 1350;
  localparam int MIN_FRAMES    = 48;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 10;
  localparam int STALL_LIMIT   = 3000;

  typedef enum int {FRAME_FULL, FRAME_BAND, FRAME_NOISE} frame_kind_t;

  // Tracks the per-bin running means and the binary words of the open frame,
  // and holds the words each closed frame must produce.
  class binary_word_predictor;
    logic [15:0] far_mean[STORE_DEPTH];
    logic [15:0] near_mean[STORE_DEPTH];
    logic [31:0] far_bits;
    logic [31:0] near_bits;
    logic        err_seen;
    bst_out_t    words_due[$];
    int          failures;
    int          bins_noted;
    int          frames_checked;
    int          flagged_frames;

    function new();
      for (int i = 0; i < STORE_DEPTH; i++) begin
        far_mean[i]  = '0;
        near_mean[i] = '0;
      end
      far_bits  = '0;
      near_bits = '0;
      err_seen  = 1'b0;
    endfunction

    // mean + floor((value - mean) / 2^shift)
    function automatic logic [15:0] smoothed(logic [15:0] mean, logic [15:0] value);
      int unsigned m;
      int unsigned v;
      m = mean;
      v = value;
      if (v >= m) return 16'(m + ((v - m) >> SMOOTH_SHIFT));
      return 16'(m - ((m - v + (1 << SMOOTH_SHIFT) - 1) >> SMOOTH_SHIFT));
    endfunction

    function void note_bin(bst_in_t b);
      int unsigned pos;
      bst_out_t    w;
      bins_noted++;
      if (b.far_q_format > MAX_FAR_Q) begin
        err_seen = 1'b1;
      end else if (b.bin_index >= BAND_FIRST && b.bin_index <= BAND_LAST) begin
        pos = b.bin_index - BAND_FIRST;
        far_mean[pos]  = smoothed(far_mean[pos], b.far_value);
        near_mean[pos] = smoothed(near_mean[pos], b.near_value);
        if (b.far_value > far_mean[pos]) far_bits[pos] = 1'b1;
        if (b.near_value > near_mean[pos]) near_bits[pos] = 1'b1;
      end
      if (b.last_bin) begin
        w.far_binary  = far_bits;
        w.near_binary = near_bits;
        w.frame_error = err_seen;
        words_due.push_back(w);
        if (err_seen) flagged_frames++;
        far_bits  = '0;
        near_bits = '0;
        err_seen  = 1'b0;
      end
    endfunction

    function void note_fail(string msg);
      failures++;
      if (failures <= 10) $display("tb: mismatch: %s", msg);
    endfunction

    function void check_frame(bst_out_t got);
      bst_out_t want;
      if (words_due.size() == 0) begin
        note_fail($sformatf("unexpected frame far=%h near=%h err=%b",
                            got.far_binary, got.near_binary, got.frame_error));
        return;
      end
      want = words_due.pop_front();
      frames_checked++;
      if (got.far_binary !== want.far_binary)
        note_fail($sformatf("frame %0d far_binary expected %h got %h",
                            frames_checked, want.far_binary, got.far_binary));
      if (got.near_binary !== want.near_binary)
        note_fail($sformatf("frame %0d near_binary expected %h got %h",
                            frames_checked, want.near_binary, got.near_binary));
      if (got.frame_error !== want.frame_error)
        note_fail($sformatf("frame %0d frame_error expected %b got %b",
                            frames_checked, want.frame_error, got.frame_error));
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic no_idle = 1'b0;
  logic hold_off_req = 1'b0;
  int   stall_cycles = 0;
  int   band_items = 0;
  int   frame_count = 0;

  binary_word_predictor predictor;

  bst_stream_if #(.T(bst_in_t))  in_bus ();
  bst_stream_if #(.T(bst_out_t)) out_bus ();

  binary_spectrum_thresholder_core #(
    .BAND_FIRST   (BAND_FIRST),
    .BAND_LAST    (BAND_LAST),
    .SPECTRUM_BINS(SPECTRUM_BINS),
    .SMOOTH_SHIFT (SMOOTH_SHIFT)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  always #10 clk = ~clk;

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 96) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic bst_in_t make_bin(int bin, logic [15:0] fv, logic [15:0] nv,
                                       logic [4:0] q, logic last);
    bst_in_t b;
    b.bin_index    = 6'(bin);
    b.far_value    = fv;
    b.near_value   = nv;
    b.far_q_format = q;
    b.last_bin     = last;
    return b;
  endfunction

  // Half the time hover around the current mean so the strict compare is exercised.
  function automatic logic [15:0] pick_value(logic [15:0] mean);
    int r;
    int v;
    r = $urandom_range(0, 9);
    if (r < 3) return 16'($urandom_range(0, 65535));
    if (r == 3) return 16'h0000;
    if (r == 4) return 16'hFFFF;
    v = int'(mean) + $urandom_range(0, 8) - 4;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return 16'(v);
  endfunction

  function automatic logic [4:0] pick_q();
    if ($urandom_range(0, 99) < 4) return 5'($urandom_range(16, 31));
    return 5'($urandom_range(0, 15));
  endfunction

  task automatic send_bin(input bst_in_t b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.data  <= b;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    predictor.note_bin(b);
    if ((b.bin_index >= BAND_FIRST && b.bin_index <= BAND_LAST) || b.last_bin ||
        b.far_q_format > MAX_FAR_Q)
      band_items++;
  endtask

  task automatic send_random_bin(input int bin, input logic last);
    int pos;
    logic [15:0] fm;
    logic [15:0] nm;
    fm = 16'($urandom_range(0, 65535));
    nm = 16'($urandom_range(0, 65535));
    if (bin >= BAND_FIRST && bin <= BAND_LAST) begin
      pos = bin - BAND_FIRST;
      fm = predictor.far_mean[pos];
      nm = predictor.near_mean[pos];
    end
    send_bin(make_bin(bin, pick_value(fm), pick_value(nm), pick_q(), last));
  endtask

  task automatic send_frame(input frame_kind_t kind);
    int start;
    int len;
    int bin;
    case (kind)
      FRAME_FULL: begin
        for (int b = 0; b < SPECTRUM_BINS; b++)
          send_random_bin(b, b == SPECTRUM_BINS - 1);
      end
      FRAME_BAND: begin
        start = $urandom_range(BAND_FIRST, BAND_LAST);
        len   = $urandom_range(1, 16);
        bin   = start;
        for (int i = 0; i < len; i++) begin
          send_random_bin(bin, i == len - 1);
          // hit the same entry again now and then
          if ($urandom_range(0, 9) != 0) bin = (bin >= BAND_LAST) ? BAND_FIRST : bin + 1;
        end
      end
      default: begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
          send_random_bin($urandom_range(0, SPECTRUM_BINS - 1), i == len - 1);
      end
    endcase
    frame_count++;
  endtask

  // Result side: random ready, plus one long hold-off on request.
  initial begin : result_sink
    int gap;
    out_bus.ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_bus.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_bus.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) predictor.check_frame(out_bus.data);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    frame_kind_t kind;
    int r;
    predictor = new();
    in_bus.valid <= 1'b0;
    in_bus.data  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // band edges at the field extremes, then ignored bins around the band
    send_bin(make_bin(12, 16'hFFFF, 16'h0000, 5'd0, 1'b0));
    send_bin(make_bin(43, 16'h0000, 16'hFFFF, 5'd15, 1'b0));
    send_bin(make_bin(0, 16'hFFFF, 16'hFFFF, 5'd0, 1'b0));
    send_bin(make_bin(11, 16'hFFFF, 16'hFFFF, 5'd3, 1'b0));
    send_bin(make_bin(44, 16'hFFFF, 16'hFFFF, 5'd3, 1'b0));
    send_bin(make_bin(63, 16'hFFFF, 16'hFFFF, 5'd3, 1'b0));
    // bad far Q drops the bin; last bin dropped too
    send_bin(make_bin(20, 16'd1234, 16'd4321, 5'd16, 1'b0));
    send_bin(make_bin(30, 16'hFFFF, 16'hFFFF, 5'd31, 1'b1));
    // last bin outside the band
    send_bin(make_bin(50, 16'd7, 16'd7, 5'd0, 1'b1));
    // same entry back to back
    send_bin(make_bin(25, 16'd100, 16'd100, 5'd0, 1'b0));
    send_bin(make_bin(25, 16'd100, 16'd100, 5'd0, 1'b0));
    send_bin(make_bin(25, 16'h0000, 16'hFFFF, 5'd0, 1'b0));
    send_bin(make_bin(25, 16'hFFFF, 16'h0000, 5'd0, 1'b1));
    // value below its mean, then equal to its mean
    send_bin(make_bin(12, 16'h0000, 16'h0000, 5'd0, 1'b1));
    send_bin(make_bin(40, 16'h0000, 16'h0000, 5'd0, 1'b1));
    send_bin(make_bin(43, 16'hFFFF, 16'hFFFF, 5'd15, 1'b1));
    send_bin(make_bin(33, 16'hFFFF, 16'hFFFF, 5'd16, 1'b1));

    while (predictor.bins_noted < ITEM_TARGET || frame_count < MIN_FRAMES) begin
      if (frame_count == 12) begin
        // stall results while short frames keep coming, to back up the input
        hold_off_req = 1'b1;
        no_idle = 1'b1;
        for (int i = 0; i < 20; i++)
          send_random_bin($urandom_range(BAND_FIRST, BAND_LAST), 1'b1);
        frame_count++;
      end
      no_idle = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 9);
      kind = (r < 3) ? FRAME_FULL : (r < 8) ? FRAME_BAND : FRAME_NOISE;
      send_frame(kind);
    end
    no_idle = 1'b0;
    in_bus.valid <= 1'b0;

    while (predictor.words_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d bins taken over %0d random frames, %0d band/last/bad-Q bins",
             predictor.bins_noted, frame_count, band_items);
    $display("tb: %0d frames checked, %0d of them flagged, %0d mismatches",
             predictor.frames_checked, predictor.flagged_frames, predictor.failures);
    if (predictor.failures == 0 && predictor.words_due.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
